// File: hw/rtl/deq_pkg.sv
// shared types and constants for the double-ended queue unit
// no dependencies; imported by deq_cell, deq_ctrl and double_ended_queue_unit
package deq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // request opcodes
   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5
   } opcode_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2
   } status_type;

   // per-cycle move applied to the whole row of cells
   typedef enum logic [1:0] {
      CMD_HOLD        = 2'd0,
      CMD_SHIFT_RIGHT = 2'd1,
      CMD_SHIFT_LEFT  = 2'd2,
      CMD_LOAD_TAIL   = 2'd3
   } cell_cmd_type;

   // which end of the row feeds the response word
   typedef enum logic [1:0] {
      RD_NONE  = 2'd0,
      RD_FRONT = 2'd1,
      RD_BACK  = 2'd2
   } read_sel_type;

   // control broadcast to every cell
   typedef struct packed {
      cell_cmd_type     cmd;
      logic [IDX_W-1:0] tail_idx;   // first free slot, target of a push back
      logic [IDX_W-1:0] back_idx;   // slot of the back entry
   } cell_ctl_type;

   // response decision handed from control to the output stage
   typedef struct packed {
      read_sel_type rd_sel;
      status_type   status;
      logic         now_empty;
   } rsp_info_type;

endpackage

// File: hw/rtl/deq_cell.sv
// one slot of the queue row: holds a word and trades it with its neighbors
// depends on deq_pkg
module deq_cell
   import deq_pkg::*;
(
   input  logic                  clock,
   input  cell_ctl_type          ctl,
   input  logic [IDX_W-1:0]      slot_idx,
   input  logic [DATA_WIDTH-1:0] left_word,
   input  logic [DATA_WIDTH-1:0] right_word,
   input  logic [DATA_WIDTH-1:0] push_word,
   output logic [DATA_WIDTH-1:0] word,
   output logic [DATA_WIDTH-1:0] back_word
);

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;

   // pick the next word from neighbor, push data or self
   always_comb begin
      word_in = word_ff;
      case (ctl.cmd)
         CMD_SHIFT_RIGHT: word_in = left_word;
         CMD_SHIFT_LEFT:  word_in = right_word;
         CMD_LOAD_TAIL: begin
            if (ctl.tail_idx == slot_idx) word_in = push_word;
         end
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word      = word_ff;
   // contribute to the back read only when this slot holds the back entry
   assign back_word = (ctl.back_idx == slot_idx) ? word_ff : '0;

endmodule

// File: hw/rtl/deq_ctrl.sv
// occupancy count and opcode decode for the queue row
// depends on deq_pkg
module deq_ctrl
   import deq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_fire,
   input  logic [2:0]   req_opcode,
   output cell_ctl_type cell_ctl,
   output rsp_info_type rsp_info
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             empty;
   logic             full;
   cell_cmd_type     cmd;
   read_sel_type     rd_sel;
   status_type       status;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));

   // decode the beat into a row move, count update and response
   always_comb begin
      cmd      = CMD_HOLD;
      rd_sel   = RD_NONE;
      status   = ST_OK;
      count_in = count_ff;
      case (req_opcode)
         OP_PUSH_FRONT: begin
            if (full) status = ST_OVER;
            else begin
               cmd      = CMD_SHIFT_RIGHT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_PUSH_BACK: begin
            if (full) status = ST_OVER;
            else begin
               cmd      = CMD_LOAD_TAIL;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_POP_FRONT: begin
            if (empty) status = ST_UNDER;
            else begin
               rd_sel   = RD_FRONT;
               cmd      = CMD_SHIFT_LEFT;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_POP_BACK: begin
            if (empty) status = ST_UNDER;
            else begin
               rd_sel   = RD_BACK;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_PEEK_FRONT: begin
            if (empty) status = ST_UNDER;
            else rd_sel = RD_FRONT;
         end
         OP_PEEK_BACK: begin
            if (empty) status = ST_UNDER;
            else rd_sel = RD_BACK;
         end
         default: begin
            cmd = CMD_HOLD;
         end
      endcase
   end

   // occupancy count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req_fire) begin
         count_ff <= count_in;
      end
   end

   // row control only moves on an accepted beat
   assign cell_ctl.cmd      = req_fire ? cmd : CMD_HOLD;
   assign cell_ctl.tail_idx = count_ff[IDX_W-1:0];
   assign cell_ctl.back_idx = IDX_W'(count_ff - CNT_W'(1));

   assign rsp_info.rd_sel    = rd_sel;
   assign rsp_info.status    = status;
   assign rsp_info.now_empty = (count_in == '0);

endmodule

// File: hw/rtl/double_ended_queue_unit.sv
// top level of the double-ended queue unit: row of cells, control, response register
// depends on deq_pkg, deq_cell and deq_ctrl
//
// usage
//   request channel (req_valid/req_ready) carries an opcode and a push word:
//   push front, push back, pop front, pop back, peek front, peek back.
//   response channel (rsp_valid/rsp_ready) returns one beat per request:
//   the word read (zero for pushes and errors), the empty flag after the
//   operation and a status (ok, underflow, overflow).
//   entries live in a row of DEPTH cells with the front always in cell 0;
//   push front and pop front shift the whole row by one cell,
//   push back loads the first free cell, pop back only drops the count.
//   the response is registered and turns valid in the cycle after the request
//   is accepted; one request is taken every cycle while the receiver keeps up,
//   set by the row shift and the response register.
//   reset empties the queue (count to zero) and drops any pending response;
//   cell contents are not cleared.
//   when the receiver stalls, the response register holds its beat and
//   req_ready falls until the beat is taken.
module double_ended_queue_unit
   import deq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_opcode,
   input  logic [DATA_WIDTH-1:0] req_push_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_read_word,
   output logic                  rsp_now_empty,
   output logic [1:0]            rsp_status
);

   cell_ctl_type          cell_ctl;
   rsp_info_type          rsp_info;
   logic                  req_fire;
   logic [DATA_WIDTH-1:0] cell_word [DEPTH];
   logic [DATA_WIDTH-1:0] cell_back [DEPTH];
   logic [DATA_WIDTH-1:0] back_word;
   logic [DATA_WIDTH-1:0] read_word;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_word_ff;
   logic                  rsp_empty_ff;
   status_type            rsp_status_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .req_opcode (req_opcode),
      .cell_ctl   (cell_ctl),
      .rsp_info   (rsp_info)
   );

   // row of cells, front at index zero
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_word;
      logic [DATA_WIDTH-1:0] right_word;
      if (i == 0) begin : g_first
         assign left_word = req_push_word;
      end else begin : g_mid
         assign left_word = cell_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_word = cell_word[i];
      end else begin : g_inner
         assign right_word = cell_word[i+1];
      end
      deq_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .slot_idx   (IDX_W'(i)),
         .left_word  (left_word),
         .right_word (right_word),
         .push_word  (req_push_word),
         .word       (cell_word[i]),
         .back_word  (cell_back[i])
      );
   end

   // gather the back entry, only one cell drives non-zero
   always_comb begin
      back_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_word = back_word | cell_back[i];
      end
   end

   // response word select
   always_comb begin
      case (rsp_info.rd_sel)
         RD_FRONT: read_word = cell_word[0];
         RD_BACK:  read_word = back_word;
         default:  read_word = '0;
      endcase
   end

   // response register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded on each accepted beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_word_ff   <= read_word;
         rsp_empty_ff  <= rsp_info.now_empty;
         rsp_status_ff <= rsp_info.status;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_word = rsp_word_ff;
   assign rsp_now_empty = rsp_empty_ff;
   assign rsp_status    = rsp_status_ff;

endmodule
